/* src/edet_pkg.sv */
// Package for the earliest-deadline event timer: sequencer state type,
// operation and event codes, timer numbers and reset constants.
// No dependencies.
package edet_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAPSE,
        ST_SET,
        ST_SCAN,
        ST_SUB,
        ST_CHECK,
        ST_DONE
    } edet_state_t;

    // Operation codes
    localparam logic [1:0] OP_SET     = 2'd0;
    localparam logic [1:0] OP_COMPARE = 2'd1;
    localparam logic [1:0] OP_ELAPSE  = 2'd2;

    // Reported event codes
    localparam logic [2:0] FIRE_NONE = 3'd0;
    localparam logic [2:0] FIRE_CMP  = 3'd1;
    localparam logic [2:0] FIRE_SI   = 3'd2;
    localparam logic [2:0] FIRE_PI   = 3'd3;
    localparam logic [2:0] FIRE_VI   = 3'd4;

    // Fixed timer numbers
    localparam int TMR_CMP = 0;
    localparam int TMR_SI  = 1;
    localparam int TMR_PI  = 2;
    localparam int TMR_VI  = 3;

    // Far-away mark for the compare timer, and "no timer selected"
    localparam logic [31:0] FAR_MARK = 32'h7FFF_FFFF;
    localparam logic [4:0]  SEL_NONE = 5'h1F;

    // Reset values
    localparam logic [31:0] COUNTDOWN_RST = 32'd5000;
    localparam logic [30:0] PERIOD_RST    = 31'd5000;

    // Compare timer value from compare minus count
    function automatic logic [30:0] compare_target(logic [31:0] d);
        logic [30:0] t;
        if (d[31])
            t = FAR_MARK[30:0];
        else if (d == 32'd0)
            t = 31'd1;
        else
            t = d[30:0];
        return t;
    endfunction

endpackage

/* src/earliest_deadline_event_timer.sv */
// Earliest-deadline event timer: timers with a shared countdown
// to the earliest armed deadline, run by a sequencer over one adder.
// Depends on edet_pkg.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------------
//  command   | start / busy          | operation, timer_id, timer_value, cycles,
//            |                       | compare_distance
//  result    | done (1-cycle strobe) | fired_event, next_timer, time_to_next
//  config    | video_period_we       | video_period
//
// One 32-bit adder/subtractor does every add; a rebase pass walks the timers
// twice (add and minimum search, then subtract), then a check step may
// re-arm the compare timer and run a second pass. An ignored item goes
// straight to done; an elapse that fires nothing ends after the countdown
// update; an elapse that fires reloads the fired timer and rebases.
// busy stays high from the accepting edge until the done beat; done is not
// held off by the receiver. Reset arms the video timer with a countdown of 5000.
module earliest_deadline_event_timer #(
    parameter int NUM_TIMERS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic [1:0]         operation,
    input  logic [3:0]         timer_id,
    input  logic [30:0]        timer_value,
    input  logic [15:0]        cycles,
    input  logic [31:0]        compare_distance,
    input  logic               video_period_we,
    input  logic [30:0]        video_period,
    output logic [2:0]         fired_event,
    output logic signed [4:0]  next_timer,
    output logic signed [31:0] time_to_next
);

    localparam int IDX_W = $clog2(NUM_TIMERS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TIMERS - 1);
    localparam logic [IDX_W-1:0] IDX_CMP  = IDX_W'(edet_pkg::TMR_CMP);
    localparam logic [IDX_W-1:0] IDX_SI   = IDX_W'(edet_pkg::TMR_SI);
    localparam logic [IDX_W-1:0] IDX_PI   = IDX_W'(edet_pkg::TMR_PI);
    localparam logic [IDX_W-1:0] IDX_VI   = IDX_W'(edet_pkg::TMR_VI);

    edet_pkg::edet_state_t state_reg, state_next;

    logic [31:0]           rt_reg [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] armed_reg, armed_next;
    logic [4:0]            sel_reg, sel_next;
    logic [31:0]           countdown_reg, countdown_next;
    logic [30:0]           vper_reg;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [31:0]           best_reg, best_next;
    logic [4:0]            nsel_reg, nsel_next;
    logic [IDX_W-1:0]      tgt_reg, tgt_next;
    logic [30:0]           tval_reg, tval_next;
    logic [2:0]            fired_reg, fired_next;
    logic                  extra_reg, extra_next;
    logic                  second_reg, second_next;
    logic [15:0]           cyc_reg, cyc_next;
    logic [31:0]           dist_reg, dist_next;

    logic                  accept;
    logic                  id_ok;
    logic                  idx_last;
    logic [31:0]           rt_rd;
    logic                  rebase_ok;
    logic                  rearm_ok;
    logic [31:0]           add_a, add_b, sum;
    logic                  add_sub;
    logic [31:0]           scan_val;
    logic                  rt_we;
    logic [IDX_W-1:0]      rt_widx;
    logic [31:0]           rt_wdata;

    assign accept   = start && !busy;
    assign id_ok    = ({1'b0, timer_id} < 5'(NUM_TIMERS));
    assign idx_last = (idx_reg == IDX_LAST);
    assign rt_rd    = rt_reg[idx_reg];

    // Armed timer takes part in rebasing unless it is the compare timer at the far mark
    assign rebase_ok = armed_reg[idx_reg] &&
                       !(idx_reg == IDX_CMP && rt_rd == edet_pkg::FAR_MARK);

    // Re-arm compare once per reschedule when it sits at the far mark
    assign rearm_ok = !second_reg && (rt_reg[0] == edet_pkg::FAR_MARK) &&
                      !dist_reg[31] && (dist_reg != edet_pkg::FAR_MARK);

    // Shared adder operand select
    always_comb
    begin
        add_a   = rt_rd;
        add_b   = countdown_reg;
        add_sub = 1'b0;
        unique case (state_reg)
            edet_pkg::ST_ELAPSE:
            begin
                add_a   = countdown_reg;
                add_b   = {16'd0, cyc_reg};
                add_sub = 1'b1;
            end
            edet_pkg::ST_SET:
            begin
                add_a   = {1'b0, tval_reg};
                add_sub = 1'b1;
            end
            edet_pkg::ST_SUB:
            begin
                add_b   = best_reg;
                add_sub = 1'b1;
            end
            edet_pkg::ST_CHECK:
            begin
                add_a   = {1'b0, edet_pkg::compare_target(dist_reg)};
                add_sub = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Shared adder/subtractor
    assign sum      = add_a + (add_sub ? ~add_b : add_b) + {31'd0, add_sub};
    assign scan_val = rebase_ok ? sum : rt_rd;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            edet_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        edet_pkg::OP_SET:
                            state_next = id_ok ? edet_pkg::ST_SET : edet_pkg::ST_DONE;
                        edet_pkg::OP_COMPARE:
                            state_next = edet_pkg::ST_SET;
                        edet_pkg::OP_ELAPSE:
                            state_next = edet_pkg::ST_ELAPSE;
                        default:
                            state_next = edet_pkg::ST_DONE;
                    endcase
                end
            end
            edet_pkg::ST_ELAPSE:
            begin
                if (!sum[31])
                    state_next = edet_pkg::ST_DONE;
                else if (sel_reg[4])
                    state_next = edet_pkg::ST_SCAN;
                else
                    state_next = edet_pkg::ST_SET;
            end
            edet_pkg::ST_SET:
                state_next = edet_pkg::ST_SCAN;
            edet_pkg::ST_SCAN:
                state_next = idx_last ? edet_pkg::ST_SUB : edet_pkg::ST_SCAN;
            edet_pkg::ST_SUB:
                state_next = idx_last ? edet_pkg::ST_CHECK : edet_pkg::ST_SUB;
            edet_pkg::ST_CHECK:
                state_next = (rearm_ok || extra_reg) ? edet_pkg::ST_SCAN
                                                     : edet_pkg::ST_DONE;
            edet_pkg::ST_DONE:
                state_next = edet_pkg::ST_IDLE;
            default:
                state_next = edet_pkg::ST_IDLE;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        armed_next     = armed_reg;
        sel_next       = sel_reg;
        countdown_next = countdown_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        nsel_next      = nsel_reg;
        tgt_next       = tgt_reg;
        tval_next      = tval_reg;
        fired_next     = fired_reg;
        extra_next     = extra_reg;
        second_next    = second_reg;
        cyc_next       = cyc_reg;
        dist_next      = dist_reg;
        rt_we          = 1'b0;
        rt_widx        = idx_reg;
        rt_wdata       = sum;

        unique case (state_reg)
            edet_pkg::ST_IDLE:
            begin
                // Latch the command beat
                if (accept)
                begin
                    cyc_next   = cycles;
                    dist_next  = compare_distance;
                    fired_next = edet_pkg::FIRE_NONE;
                    extra_next = 1'b0;
                    unique case (operation)
                        edet_pkg::OP_SET:
                        begin
                            tgt_next  = timer_id[IDX_W-1:0];
                            tval_next = timer_value;
                        end
                        edet_pkg::OP_COMPARE:
                        begin
                            tgt_next  = IDX_CMP;
                            tval_next = edet_pkg::compare_target(compare_distance);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            edet_pkg::ST_ELAPSE:
            begin
                // Advance the countdown; pick the firing timer's new value
                countdown_next = sum;
                second_next    = 1'b0;
                if (sum[31] && !sel_reg[4])
                begin
                    extra_next = 1'b1;
                    tgt_next   = sel_reg[IDX_W-1:0];
                    priority if (sel_reg[IDX_W-1:0] == IDX_CMP)
                    begin
                        fired_next = edet_pkg::FIRE_CMP;
                        tval_next  = edet_pkg::compare_target(dist_reg);
                    end
                    else if (sel_reg[IDX_W-1:0] == IDX_SI)
                    begin
                        fired_next = edet_pkg::FIRE_SI;
                        tval_next  = 31'd0;
                    end
                    else if (sel_reg[IDX_W-1:0] == IDX_PI)
                    begin
                        fired_next = edet_pkg::FIRE_PI;
                        tval_next  = 31'd0;
                    end
                    else if (sel_reg[IDX_W-1:0] == IDX_VI)
                    begin
                        fired_next = edet_pkg::FIRE_VI;
                        tval_next  = vper_reg;
                    end
                    else
                    begin
                        fired_next = edet_pkg::FIRE_NONE;
                        tval_next  = 31'd0;
                    end
                end
            end
            edet_pkg::ST_SET:
            begin
                // Arm relative to the countdown, or drop the timer
                rt_we       = 1'b1;
                rt_widx     = tgt_reg;
                second_next = 1'b0;
                if (tval_reg != 31'd0)
                begin
                    rt_wdata            = sum;
                    armed_next[tgt_reg] = 1'b1;
                end
                else
                begin
                    rt_wdata            = 32'd0;
                    armed_next[tgt_reg] = 1'b0;
                end
            end
            edet_pkg::ST_SCAN:
            begin
                // Rebase by the countdown and track the earliest deadline
                rt_we    = 1'b1;
                rt_wdata = scan_val;
                if (armed_reg[idx_reg] && ($signed(scan_val) < $signed(best_reg)))
                begin
                    best_next = scan_val;
                    nsel_next = 5'(idx_reg);
                end
                idx_next = idx_last ? '0 : idx_reg + 1'b1;
            end
            edet_pkg::ST_SUB:
            begin
                // Make deadlines relative to the new countdown
                rt_we    = rebase_ok;
                rt_wdata = sum;
                idx_next = idx_last ? '0 : idx_reg + 1'b1;
                if (idx_last)
                begin
                    countdown_next = best_reg;
                    sel_next       = nsel_reg;
                end
            end
            edet_pkg::ST_CHECK:
            begin
                if (rearm_ok)
                begin
                    rt_we         = 1'b1;
                    rt_widx       = IDX_CMP;
                    rt_wdata      = sum;
                    armed_next[0] = 1'b1;
                    second_next   = 1'b1;
                end
                else if (extra_reg)
                begin
                    extra_next  = 1'b0;
                    second_next = 1'b0;
                end
            end
            edet_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // Open a rebase pass
        if (state_next == edet_pkg::ST_SCAN && state_reg != edet_pkg::ST_SCAN)
        begin
            idx_next  = '0;
            best_next = edet_pkg::FAR_MARK;
            nsel_next = edet_pkg::SEL_NONE;
        end
    end

    // Control and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= edet_pkg::ST_IDLE;
            armed_reg     <= NUM_TIMERS'(1) << edet_pkg::TMR_VI;
            sel_reg       <= 5'(edet_pkg::TMR_VI);
            countdown_reg <= edet_pkg::COUNTDOWN_RST;
            vper_reg      <= edet_pkg::PERIOD_RST;
            idx_reg       <= '0;
            extra_reg     <= 1'b0;
            second_reg    <= 1'b0;
            for (int k = 0; k < NUM_TIMERS; k++)
                rt_reg[k] <= 32'd0;
        end
        else
        begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            sel_reg       <= sel_next;
            countdown_reg <= countdown_next;
            idx_reg       <= idx_next;
            extra_reg     <= extra_next;
            second_reg    <= second_next;
            if (video_period_we)
                vper_reg <= video_period;
            if (rt_we)
                rt_reg[rt_widx] <= rt_wdata;
        end
    end

    // Per-item payload
    always_ff @(posedge clk)
    begin
        best_reg  <= best_next;
        nsel_reg  <= nsel_next;
        tgt_reg   <= tgt_next;
        tval_reg  <= tval_next;
        fired_reg <= fired_next;
        cyc_reg   <= cyc_next;
        dist_reg  <= dist_next;
    end

    assign busy         = (state_reg != edet_pkg::ST_IDLE);
    assign done         = (state_reg == edet_pkg::ST_DONE);
    assign fired_event  = fired_reg;
    assign next_timer   = $signed(sel_reg);
    assign time_to_next = $signed(countdown_reg);

`ifndef SYNTHESIS
    // Selection is either none or a real timer number
    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sel_reg == edet_pkg::SEL_NONE) || (sel_reg < 5'(NUM_TIMERS)))
        else $error("selected timer out of range");

    // A selected timer is armed when the result goes out
    a_sel_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !sel_reg[4]) |-> armed_reg[sel_reg[IDX_W-1:0]])
        else $error("selected timer is not armed");

    // Accepted command starts the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("command accepted but sequencer idle");

    // Result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Scan hands over to the subtract walk after the last timer
    a_scan_to_sub: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == edet_pkg::ST_SCAN && idx_last) |=>
            (state_reg == edet_pkg::ST_SUB && idx_reg == '0))
        else $error("scan did not hand over to subtract walk");
`endif

endmodule

/* bench/edet_timer_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the earliest-deadline event timer: watches the command,
// config and result channels, predicts each result and compares it.
// Depends on edet_pkg.
module edet_timer_checker #(
    parameter int NUM_TIMERS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               done,
    input  logic [1:0]         operation,
    input  logic [3:0]         timer_id,
    input  logic [30:0]        timer_value,
    input  logic [15:0]        cycles,
    input  logic [31:0]        compare_distance,
    input  logic               video_period_we,
    input  logic [30:0]        video_period,
    input  logic [2:0]         fired_event,
    input  logic signed [4:0]  next_timer,
    input  logic signed [31:0] time_to_next,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        logic [2:0]         fired;
        logic signed [4:0]  next_idx;
        logic signed [31:0] countdown;
    } sched_result_t;

    // Expected results, oldest first
    sched_result_t expected_q[$];
    sched_result_t want;

    // Shadow copy of the scheduler state
    logic [31:0] remaining [NUM_TIMERS];
    logic        armed [NUM_TIMERS];
    int          sel_idx;
    logic [31:0] countdown_now;
    logic [31:0] period_now;
    logic [31:0] distance_now;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [31:0] compare_goal(input logic [31:0] d);
        logic [31:0] t;
        t = d;
        if (t[31])
            t = edet_pkg::FAR_MARK;
        if (t == 32'd0)
            t = 32'd1;
        return t;
    endfunction

    // The compare timer parked at the far mark is left out of rebasing
    function automatic bit is_rebasable(input int i);
        return !(i == edet_pkg::TMR_CMP && remaining[i] == edet_pkg::FAR_MARK);
    endfunction

    // Fold the countdown back in, pick the earliest deadline, rebase on it
    function automatic void rebase_timers();
        int          sel;
        logic [31:0] best;
        sel  = -1;
        best = edet_pkg::FAR_MARK;
        for (int i = 0; i < NUM_TIMERS; i++)
            if (armed[i] && is_rebasable(i))
                remaining[i] = remaining[i] + countdown_now;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (armed[i] && $signed(remaining[i]) < $signed(best))
            begin
                best = remaining[i];
                sel  = i;
            end
        end
        for (int i = 0; i < NUM_TIMERS; i++)
            if (armed[i] && is_rebasable(i))
                remaining[i] = remaining[i] - best;
        countdown_now = best;
        sel_idx       = sel;
    endfunction

    // Rebase, then re-arm a parked compare timer once if the distance allows
    function automatic void reselect_earliest();
        logic [31:0] d;
        d = distance_now;
        rebase_timers();
        if (remaining[edet_pkg::TMR_CMP] == edet_pkg::FAR_MARK && !d[31] &&
            d != edet_pkg::FAR_MARK)
        begin
            remaining[edet_pkg::TMR_CMP] = compare_goal(d) - countdown_now;
            armed[edet_pkg::TMR_CMP]     = 1'b1;
            rebase_timers();
        end
    endfunction

    function automatic void load_timer(input int id, input logic [31:0] value);
        if (value != 32'd0)
        begin
            remaining[id] = value - countdown_now;
            armed[id]     = 1'b1;
        end
        else
        begin
            remaining[id] = 32'd0;
            armed[id]     = 1'b0;
        end
        reselect_earliest();
    endfunction

    function automatic void reset_schedule();
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            remaining[i] = 32'd0;
            armed[i]     = 1'b0;
        end
        armed[edet_pkg::TMR_VI] = 1'b1;
        sel_idx       = edet_pkg::TMR_VI;
        countdown_now = edet_pkg::COUNTDOWN_RST;
        period_now    = {1'b0, edet_pkg::PERIOD_RST};
        distance_now  = 32'd0;
    endfunction

    // Advance the shadow scheduler by one command beat
    function automatic sched_result_t schedule_step(input logic [1:0] op,
                                                    input logic [3:0] id,
                                                    input logic [30:0] value,
                                                    input logic [15:0] cyc,
                                                    input logic [31:0] distance);
        sched_result_t r;
        logic [2:0]    fired;
        int            s;
        fired        = edet_pkg::FIRE_NONE;
        distance_now = distance;
        case (op)
            edet_pkg::OP_SET:
            begin
                if (int'(id) < NUM_TIMERS)
                    load_timer(int'(id), {1'b0, value});
            end
            edet_pkg::OP_COMPARE:
                load_timer(edet_pkg::TMR_CMP, compare_goal(distance_now));
            edet_pkg::OP_ELAPSE:
            begin
                countdown_now = countdown_now - {16'd0, cyc};
                if ($signed(countdown_now) < 0)
                begin
                    s = sel_idx;
                    if (s == edet_pkg::TMR_CMP)
                    begin
                        fired = edet_pkg::FIRE_CMP;
                        load_timer(edet_pkg::TMR_CMP, compare_goal(distance_now));
                    end
                    else if (s == edet_pkg::TMR_SI)
                    begin
                        fired = edet_pkg::FIRE_SI;
                        load_timer(edet_pkg::TMR_SI, 32'd0);
                    end
                    else if (s == edet_pkg::TMR_PI)
                    begin
                        fired = edet_pkg::FIRE_PI;
                        load_timer(edet_pkg::TMR_PI, 32'd0);
                    end
                    else if (s == edet_pkg::TMR_VI)
                    begin
                        fired = edet_pkg::FIRE_VI;
                        load_timer(edet_pkg::TMR_VI, period_now);
                    end
                    else if (s >= 0 && s < NUM_TIMERS)
                        load_timer(s, 32'd0);
                    reselect_earliest();
                end
            end
            default:
                ;
        endcase
        r.fired     = fired;
        r.next_idx  = sel_idx[4:0];
        r.countdown = countdown_now;
        return r;
    endfunction

    function automatic void report_mismatch(input string field, input longint exp_v,
                                            input longint act_v);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, field, exp_v, act_v);
    endfunction

    // Check result beats, track the register, predict accepted command beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_schedule();
            expected_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected, actual %0d %0d %0d",
                             $time, fired_event, next_timer, time_to_next);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (fired_event !== want.fired)
                        report_mismatch("fired_event", want.fired, fired_event);
                    if (next_timer !== want.next_idx)
                        report_mismatch("next_timer", want.next_idx, next_timer);
                    if (time_to_next !== want.countdown)
                        report_mismatch("time_to_next", want.countdown, time_to_next);
                end
            end
            if (video_period_we)
                period_now = {1'b0, video_period};
            if (start && !busy)
                expected_q.push_back(schedule_step(operation, timer_id, timer_value,
                                                   cycles, compare_distance));
        end
        pending = expected_q.size();
    end

endmodule

/* bench/earliest_deadline_event_timer_tb.sv */
`timescale 1ns / 100ps
// Top of the event timer bench: clock, reset, command and config stimulus,
// and the verdict. Depends on edet_pkg and edet_timer_checker.
module earliest_deadline_event_timer_tb;

    localparam int         NUM_TIMERS = 4;
    localparam int         PHASE_ITEMS = 405;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [1:0]         operation = edet_pkg::OP_SET;
    logic [3:0]         timer_id = 4'd0;
    logic [30:0]        timer_value = 31'd0;
    logic [15:0]        cycles = 16'd0;
    logic [31:0]        compare_distance = 32'd0;
    logic               video_period_we = 1'b0;
    logic [30:0]        video_period = edet_pkg::PERIOD_RST;
    logic               busy;
    logic               done;
    logic [2:0]         fired_event;
    logic signed [4:0]  next_timer;
    logic signed [31:0] time_to_next;
    int                 fail_count;
    int                 pending;

    always #5 clk = ~clk;

    earliest_deadline_event_timer #(
        .NUM_TIMERS(NUM_TIMERS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .done(done),
        .operation(operation),
        .timer_id(timer_id),
        .timer_value(timer_value),
        .cycles(cycles),
        .compare_distance(compare_distance),
        .video_period_we(video_period_we),
        .video_period(video_period),
        .fired_event(fired_event),
        .next_timer(next_timer),
        .time_to_next(time_to_next)
    );

    edet_timer_checker #(
        .NUM_TIMERS(NUM_TIMERS)
    ) chk (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .done(done),
        .operation(operation),
        .timer_id(timer_id),
        .timer_value(timer_value),
        .cycles(cycles),
        .compare_distance(compare_distance),
        .video_period_we(video_period_we),
        .video_period(video_period),
        .fired_event(fired_event),
        .next_timer(next_timer),
        .time_to_next(time_to_next),
        .fail_count(fail_count),
        .pending(pending)
    );

    // Present one command beat and hold it until the block takes it
    task automatic send_cmd(input logic [1:0] op, input logic [3:0] id,
                            input logic [30:0] value, input logic [15:0] cyc,
                            input logic [31:0] distance);
        start            <= 1'b1;
        operation        <= op;
        timer_id         <= id;
        timer_value      <= value;
        cycles           <= cyc;
        compare_distance <= distance;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Sometimes drop start for a random gap, short or long
    task automatic maybe_idle(input int idle_pct);
        int gap;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60)
                                              : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    // Hold off until every expected result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_period(input logic [30:0] value);
        wait_drained();
        video_period_we <= 1'b1;
        video_period    <= value;
        @(posedge clk);
        video_period_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [30:0] pick_value();
        logic [30:0] v;
        case ($urandom_range(0, 9))
            0:       v = 31'd0;
            1:       v = 31'h7FFF_FFFF;
            2:       v = 31'($urandom());
            3:       v = 31'($urandom_range(1, 200));
            4:       v = 31'($urandom_range(20000, 2000000));
            default: v = 31'($urandom_range(1, 20000));
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_cycles();
        logic [15:0] c;
        case ($urandom_range(0, 9))
            0:       c = 16'd0;
            1:       c = 16'hFFFF;
            2:       c = 16'($urandom());
            default: c = 16'($urandom_range(1, 6000));
        endcase
        return c;
    endfunction

    function automatic logic [31:0] pick_distance();
        logic [31:0] d;
        case ($urandom_range(0, 11))
            0:       d = 32'd0;
            1:       d = edet_pkg::FAR_MARK;
            2:       d = 32'h8000_0000;
            3:       d = $urandom();
            4:       d = 32'hFFFF_FFFF;
            5:       d = 32'h8000_0000 | $urandom();
            default: d = $urandom_range(1, 30000);
        endcase
        return d;
    endfunction

    // Random command beats, ignored ones included
    task automatic run_random(input int count, input int idle_pct);
        int          n;
        int          r;
        logic [1:0]  op;
        logic [3:0]  id;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                op = edet_pkg::OP_SET;
            else if (r < 55)
                op = edet_pkg::OP_COMPARE;
            else if (r < 95)
                op = edet_pkg::OP_ELAPSE;
            else
                op = OP_UNUSED;
            if ($urandom_range(0, 9) == 0)
                id = 4'($urandom_range(NUM_TIMERS, 15));
            else
                id = 4'($urandom_range(0, NUM_TIMERS - 1));
            send_cmd(op, id, pick_value(), pick_cycles(), pick_distance());
            n++;
            if ($urandom_range(0, 149) == 0)
                wait_drained();
            else
                maybe_idle(idle_pct);
        end
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every operation, firing of each timer
        send_cmd(edet_pkg::OP_ELAPSE, 4'd0, 31'd0, 16'd0, 32'd0);
        send_cmd(OP_UNUSED, 4'hF, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(edet_pkg::OP_SET, 4'hF, 31'h7FFF_FFFF, 16'd0, 32'd0);
        send_cmd(edet_pkg::OP_SET, 4'(edet_pkg::TMR_SI), 31'd1, 16'd0, 32'd0);
        send_cmd(edet_pkg::OP_ELAPSE, 4'd0, 31'd0, 16'd2, 32'd0);
        send_cmd(edet_pkg::OP_SET, 4'(edet_pkg::TMR_PI), 31'h7FFF_FFFF, 16'd0, 32'd0);
        send_cmd(edet_pkg::OP_SET, 4'(edet_pkg::TMR_PI), 31'd0, 16'd0, 32'd0);
        send_cmd(edet_pkg::OP_COMPARE, 4'd0, 31'd0, 16'd0, 32'd0);
        send_cmd(edet_pkg::OP_ELAPSE, 4'd0, 31'd0, 16'hFFFF, 32'd0);
        send_cmd(edet_pkg::OP_COMPARE, 4'd0, 31'd0, 16'd0, 32'h8000_0000);
        send_cmd(edet_pkg::OP_COMPARE, 4'd0, 31'd0, 16'd0, edet_pkg::FAR_MARK);
        send_cmd(edet_pkg::OP_COMPARE, 4'd0, 31'd0, 16'd0, 32'hFFFF_FFFF);
        send_cmd(edet_pkg::OP_SET, 4'(edet_pkg::TMR_CMP), 31'd100, 16'd0, 32'd500);
        send_cmd(edet_pkg::OP_SET, 4'(edet_pkg::TMR_VI), 31'd0, 16'd0, 32'd500);
        send_cmd(edet_pkg::OP_SET, 4'(edet_pkg::TMR_CMP), 31'd0, 16'd0, 32'h8000_0000);
        send_cmd(edet_pkg::OP_ELAPSE, 4'd0, 31'd0, 16'hFFFF, 32'h8000_0000);
        send_cmd(edet_pkg::OP_SET, 4'(edet_pkg::TMR_VI), 31'd1, 16'd0, 32'h8000_0000);
        send_cmd(edet_pkg::OP_ELAPSE, 4'd0, 31'd0, 16'hFFFF, 32'h8000_0000);
        send_cmd(edet_pkg::OP_SET, 4'(edet_pkg::TMR_SI), 31'h7FFF_FFFF, 16'd0,
                 32'h8000_0000);
        send_cmd(edet_pkg::OP_SET, 4'(edet_pkg::TMR_PI), 31'd3, 16'd0, 32'h8000_0000);
        send_cmd(edet_pkg::OP_ELAPSE, 4'd0, 31'd0, 16'd10, 32'h8000_0000);
        send_cmd(edet_pkg::OP_SET, 4'd4, 31'd10, 16'd0, 32'd0);
        send_cmd(edet_pkg::OP_ELAPSE, 4'd0, 31'd0, 16'hFFFF, 32'd12345);
        send_cmd(edet_pkg::OP_COMPARE, 4'd0, 31'd0, 16'd0, 32'd12345);
        send_cmd(edet_pkg::OP_ELAPSE, 4'd0, 31'd0, 16'd0, edet_pkg::FAR_MARK);

        // Random phases, each under its own video period and idle rate
        write_period(31'h7FFF_FFFF);
        run_random(PHASE_ITEMS, 0);
        write_period(31'd1);
        run_random(PHASE_ITEMS, 70);
        write_period(31'($urandom_range(2, 100000)));
        run_random(PHASE_ITEMS, 36);
        write_period(edet_pkg::PERIOD_RST);
        run_random(PHASE_ITEMS, 0);

        // Drain, then watch for stray result beats
        wait_drained();
        repeat (50)
            @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* earliest_deadline_event_timer.f */
src/edet_pkg.sv
src/earliest_deadline_event_timer.sv
bench/edet_timer_checker.sv
bench/earliest_deadline_event_timer_tb.sv
